// ===== hdl/pddr_pkg.sv =====
`timescale 1ns / 1ps

package pddr_pkg;

  localparam int DIST_W      = 13;
  localparam int GAIN_W      = 16;
  localparam int ACCEL_W     = 10;
  localparam int TICK_W      = 16;
  localparam int CMD_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int GOAL_W      = 24;
  localparam int SUM_W       = 40;
  localparam int CAP_W       = 24;
  localparam int PID_LIM_EXP = 40;

  localparam int DEG_Q16_W = 20;
  localparam logic [DEG_Q16_W-1:0] DEG_PER_CM_Q16 = 20'd739161;
  localparam int GOAL_ROUND = 32768;
  localparam int GOAL_FRAC  = 16;

  localparam logic [CAP_W-2:0] CAP_MAX = '1;
  localparam int CMD_LIMIT_Q8 = 25600;
  localparam int CMD_FRAC     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_DISTANCE,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_INTEGRAL_RESET_LIMIT,
    CFG_ACCEL_TICKS,
    CFG_RAMP_STEP,
    CFG_RUN_TICKS
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_TICK,
    KIND_DONE
  } item_kind_e;

endpackage

// ===== hdl/pid_distance_drive_ramp_core.sv =====
`timescale 1ns / 1ps

// Distance drive PID controller with a ramped speed cap. A word with func 0 starts a move
// and loads the goal angle from target_distance; a word with func 1 is one control tick
// carrying the measured wheel angle. Every accepted word gives exactly one result word,
// and while the output is not stalled a new word can be accepted in every cycle, so the
// sustained rate is one word per cycle. The rate is set by the update of the error,
// integral, tick and cap registers; the gain products, the PID sum and the output
// limiting follow in further pipeline stages and the output register.
module pid_distance_drive_ramp_core #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int ANGLE_WIDTH    = 21
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pddr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pddr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic signed [ANGLE_WIDTH-1:0]       measured_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pddr_pkg::CMD_W-1:0]   motor_command_o,
  output logic                                done_res_o
);
  import pddr_pkg::*;

  localparam int EW  = ((ANGLE_WIDTH > GOAL_W) ? ANGLE_WIDTH : GOAL_W) + 1;
  localparam int DW  = EW + 1;
  localparam int PW  = EW + GAIN_W + 1;
  localparam int IW  = SUM_W + GAIN_W + 1;
  localparam int DPW = DW + GAIN_W + 1;
  localparam int SW  = ((IW > DPW) ? IW : DPW) + 2;
  localparam int PCW = PID_LIM_EXP + 2;
  localparam int SHR = (GAIN_FRAC_BITS >= 8) ? GAIN_FRAC_BITS - 8 : 0;
  localparam int SHL = (GAIN_FRAC_BITS < 8) ? 8 - GAIN_FRAC_BITS : 0;
  localparam int MW  = PID_LIM_EXP + 1 + SHL;
  localparam int VW  = MW + 1;
  localparam int GOAL_PROD_W = DIST_W + DEG_Q16_W;
  localparam int GOAL_MAG_W  = GOAL_PROD_W - GOAL_FRAC;
  localparam int CAP_PROD_W  = TICK_W + GAIN_W;

  localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_LO = {2'b11, {(SUM_W-1){1'b0}}};
  localparam logic signed [SW-1:0] PID_HI =
    {{(SW-PID_LIM_EXP-1){1'b0}}, 1'b1, {PID_LIM_EXP{1'b0}}};
  localparam logic signed [SW-1:0] PID_LO = -PID_HI;
  localparam logic signed [VW-1:0] CMD_HI = VW'(CMD_LIMIT_Q8);
  localparam logic signed [VW-1:0] CMD_LO = -CMD_HI;

  // Configuration registers.
  logic signed [DIST_W-1:0]  target_distance_q;
  logic [GAIN_W-1:0]         gain_p_q, gain_i_q, gain_d_q;
  logic [GAIN_W-1:0]         int_limit_q;
  logic [ACCEL_W-1:0]        accel_ticks_q;
  logic [GAIN_W-1:0]         ramp_step_q;
  logic [TICK_W-1:0]         run_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_distance_q <= '0;
      gain_p_q          <= GAIN_W'(256);
      gain_i_q          <= '0;
      gain_d_q          <= '0;
      int_limit_q       <= GAIN_W'(200);
      accel_ticks_q     <= ACCEL_W'(34);
      ramp_step_q       <= GAIN_W'(768);
      run_ticks_q       <= TICK_W'(334);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TARGET_DISTANCE:      target_distance_q <= cfg_data_i[DIST_W-1:0];
        CFG_GAIN_P:               gain_p_q          <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:               gain_i_q          <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:               gain_d_q          <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEGRAL_RESET_LIMIT: int_limit_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_ACCEL_TICKS:          accel_ticks_q     <= cfg_data_i[ACCEL_W-1:0];
        CFG_RAMP_STEP:            ramp_step_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_RUN_TICKS:            run_ticks_q       <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  logic dist_neg, dist_pos;
  assign dist_neg = target_distance_q[DIST_W-1];
  assign dist_pos = !dist_neg && (target_distance_q != '0);

  // Goal angle is registered from the distance register and follows it in the next cycle.
  logic [DIST_W-1:0]         dist_mag;
  logic [GOAL_PROD_W-1:0]    goal_prod;
  logic [GOAL_MAG_W-1:0]     goal_mag;
  logic signed [GOAL_W-1:0]  goal_pos, goal_calc_d, goal_calc_q;

  always_comb begin
    dist_mag    = dist_neg ? DIST_W'(-target_distance_q) : DIST_W'(target_distance_q);
    goal_prod   = GOAL_PROD_W'(dist_mag) * GOAL_PROD_W'(DEG_PER_CM_Q16)
                + GOAL_PROD_W'(GOAL_ROUND);
    goal_mag    = goal_prod[GOAL_PROD_W-1:GOAL_FRAC];
    goal_pos    = GOAL_W'($signed({1'b0, goal_mag}));
    goal_calc_d = dist_neg ? -goal_pos : goal_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_calc_q <= '0;
    end else begin
      goal_calc_q <= goal_calc_d;
    end
  end

  // Pipeline control.
  logic adv, in_acc;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign in_acc      = in_valid_i && adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_acc;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // Stage 1: input register.
  logic                          func1_q;
  logic signed [ANGLE_WIDTH-1:0] meas1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func1_q <= func_i;
      meas1_q <= measured_angle_i;
    end
  end

  // Move state and its update.
  logic signed [GOAL_W-1:0] goal_angle_q;
  logic signed [EW-1:0]     prev_err_q;
  logic signed [SUM_W-1:0]  esum_q;
  logic signed [CAP_W-1:0]  cap_q;
  logic [TICK_W-1:0]        tick_q;

  logic signed [EW-1:0]     err_d;
  logic [EW-1:0]            aerr;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  esum_d;
  logic signed [DW-1:0]     deriv_d;
  logic [CAP_PROD_W-1:0]    cap_prod;
  logic [CAP_W-2:0]         cap_mag;
  logic signed [CAP_W-1:0]  cap_pos, cap_d;
  logic                     done_d;
  item_kind_e               kind1;

  always_comb begin
    err_d   = EW'(goal_angle_q) - EW'(meas1_q);
    aerr    = err_d[EW-1] ? EW'(-err_d) : EW'(err_d);
    sum_ext = (SUM_W+1)'(esum_q) + (SUM_W+1)'(err_d);
    if (sum_ext > SUM_HI) begin
      esum_d = SUM_HI[SUM_W-1:0];
    end else if (sum_ext < SUM_LO) begin
      esum_d = SUM_LO[SUM_W-1:0];
    end else begin
      esum_d = sum_ext[SUM_W-1:0];
    end
    if (aerr > EW'(int_limit_q)) begin
      esum_d = '0;
    end
    deriv_d  = DW'(err_d) - DW'(prev_err_q);
    cap_prod = CAP_PROD_W'(tick_q) * CAP_PROD_W'(ramp_step_q);
    cap_mag  = (cap_prod > CAP_PROD_W'(CAP_MAX)) ? CAP_MAX : cap_prod[CAP_W-2:0];
    cap_pos  = $signed({1'b0, cap_mag});
    cap_d    = (tick_q < TICK_W'(accel_ticks_q)) ? (dist_neg ? -cap_pos : cap_pos) : cap_q;
    done_d   = tick_q >= run_ticks_q;
    if (!func1_q) begin
      kind1 = KIND_START;
    end else if (done_d) begin
      kind1 = KIND_DONE;
    end else begin
      kind1 = KIND_TICK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_angle_q <= '0;
      prev_err_q   <= '0;
      esum_q       <= '0;
      cap_q        <= '0;
      tick_q       <= '0;
    end else if (v1_q && adv) begin
      case (kind1)
        KIND_START: begin
          goal_angle_q <= goal_calc_q;
          prev_err_q   <= '0;
          esum_q       <= '0;
          cap_q        <= '0;
          tick_q       <= '0;
        end
        KIND_TICK: begin
          prev_err_q <= err_d;
          esum_q     <= esum_d;
          cap_q      <= cap_d;
          tick_q     <= tick_q + TICK_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Stage 2: error terms of the word.
  item_kind_e               kind2_q;
  logic signed [EW-1:0]     err2_q;
  logic signed [SUM_W-1:0]  esum2_q;
  logic signed [DW-1:0]     deriv2_q;
  logic signed [CAP_W-1:0]  cap2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind2_q  <= kind1;
      err2_q   <= err_d;
      esum2_q  <= esum_d;
      deriv2_q <= deriv_d;
      cap2_q   <= cap_d;
    end
  end

  // Stage 3: gain products.
  item_kind_e               kind3_q;
  logic signed [PW-1:0]     p3_q;
  logic signed [IW-1:0]     i3_q;
  logic signed [DPW-1:0]    d3_q;
  logic signed [CAP_W-1:0]  cap3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind3_q <= kind2_q;
      p3_q    <= PW'($signed({1'b0, gain_p_q})) * PW'(err2_q);
      i3_q    <= IW'($signed({1'b0, gain_i_q})) * IW'(esum2_q);
      d3_q    <= DPW'($signed({1'b0, gain_d_q})) * DPW'(deriv2_q);
      cap3_q  <= cap2_q;
    end
  end

  // Stage 4: PID sum, limit and conversion to Q8.8 percent.
  logic signed [SW-1:0]  pid_sum;
  logic signed [PCW-1:0] pid_c;
  logic [PCW-2:0]        pid_mag;
  logic [MW-1:0]         mag_s;
  logic signed [VW-1:0]  v_d;

  always_comb begin
    pid_sum = SW'(p3_q) + SW'(i3_q) + SW'(d3_q);
    if (pid_sum > PID_HI) begin
      pid_c = PID_HI[PCW-1:0];
    end else if (pid_sum < PID_LO) begin
      pid_c = PID_LO[PCW-1:0];
    end else begin
      pid_c = pid_sum[PCW-1:0];
    end
    pid_mag = pid_c[PCW-1] ? (PCW-1)'(-pid_c) : (PCW-1)'(pid_c);
    mag_s   = (MW'(pid_mag) >> SHR) << SHL;
    v_d     = pid_c[PCW-1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  end

  item_kind_e               kind4_q;
  logic signed [VW-1:0]     v4_val_q;
  logic signed [CAP_W-1:0]  cap4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind4_q  <= kind3_q;
      v4_val_q <= v_d;
      cap4_q   <= cap3_q;
    end
  end

  // Stage 5: cap, saturation and the output register.
  logic signed [VW-1:0]    cap_v, lim_v, sat_v;
  logic [VW-1:0]           sat_mag;
  logic [CMD_W-2:0]        cmd_mag;
  logic signed [CMD_W-1:0] cmd_pid, cmd_sel, last_cmd_q, motor_command_q;
  logic                    done_sel, done_res_q;

  always_comb begin
    cap_v = VW'(cap4_q);
    if (dist_pos) begin
      lim_v = (cap_v < v4_val_q) ? cap_v : v4_val_q;
    end else begin
      lim_v = (cap_v > v4_val_q) ? cap_v : v4_val_q;
    end
    if (lim_v > CMD_HI) begin
      sat_v = CMD_HI;
    end else if (lim_v < CMD_LO) begin
      sat_v = CMD_LO;
    end else begin
      sat_v = lim_v;
    end
    sat_mag = sat_v[VW-1] ? VW'(-sat_v) : VW'(sat_v);
    cmd_mag = sat_mag[CMD_FRAC +: CMD_W-1];
    cmd_pid = sat_v[VW-1] ? -$signed({1'b0, cmd_mag}) : $signed({1'b0, cmd_mag});
    case (kind4_q)
      KIND_START: begin
        cmd_sel  = '0;
        done_sel = 1'b0;
      end
      KIND_DONE: begin
        cmd_sel  = last_cmd_q;
        done_sel = 1'b1;
      end
      default: begin
        cmd_sel  = cmd_pid;
        done_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q <= '0;
    end else if (v4_q && adv) begin
      last_cmd_q <= cmd_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      motor_command_q <= cmd_sel;
      done_res_q      <= done_sel;
    end
  end

  assign motor_command_o = motor_command_q;
  assign done_res_o      = done_res_q;

endmodule

// ===== hdl/pddr_checker.sv =====
`timescale 1ns / 1ps

module pddr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] motor_command_o,
  input logic       done_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(motor_command_o) && $stable(done_res_o))
    else $error("Stalled result word changed or vanished.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the output was free.");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ($signed(motor_command_o) <= 8'sd100) && ($signed(motor_command_o) >= -8'sd100))
    else $error("Motor command outside the percent range.");

  a_done_keeps_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && done_res_o ##1 out_valid_o && done_res_o |->
      motor_command_o == $past(motor_command_o))
    else $error("Command changed between two done words.");

endmodule

bind pid_distance_drive_ramp_core pddr_checker u_pddr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .motor_command_o (motor_command_o),
  .done_res_o      (done_res_o)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pddr_pkg::*;

  localparam int GAIN_FRAC = 8;
  localparam int ANGLE_W = 21;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 900;
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint PID_LIM = 64'sd1 <<< PID_LIM_EXP;
  localparam longint CAP_LIM = (64'sd1 <<< (CAP_W - 1)) - 1;

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_cm;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] ilim;
    logic [ACCEL_W-1:0] accel;
    logic [GAIN_W-1:0] step;
    logic [TICK_W-1:0] run;
  } drive_cfg_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd;
    logic done;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic func;
  logic signed [ANGLE_W-1:0] angle;
  logic out_valid;
  logic out_stall;
  logic signed [CMD_W-1:0] motor_cmd;
  logic done_res;

  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;
  logic rx_hold;
  event hold_ev;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int words_sent = 0;

  drive_cfg_t cfg_now;
  logic signed [GOAL_W-1:0] goal_ang = '0;
  logic signed [GOAL_W-1:0] prev_err = '0;
  logic signed [SUM_W-1:0] err_sum = '0;
  logic signed [CAP_W-1:0] speed_cap = '0;
  logic [TICK_W-1:0] tick_cnt = '0;
  logic signed [CMD_W-1:0] last_cmd = '0;
  drive_result_t pending_cmds[$];

  pid_distance_drive_ramp_core #(
    .GAIN_FRAC_BITS(GAIN_FRAC),
    .ANGLE_WIDTH(ANGLE_W)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .func_i(func),
    .measured_angle_i(angle),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .motor_command_o(motor_cmd),
    .done_res_o(done_res)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  task automatic predict_drive(input logic fn, input logic signed [ANGLE_W-1:0] ang);
    longint dist_v, err, aerr, deriv, pid, v, mag, sum, capv;
    drive_result_t r;
    dist_v = longint'($signed(cfg_now.dist_cm));
    r.cmd = '0;
    r.done = 1'b0;
    if (fn == FUNC_START) begin
      mag = dist_v < 0 ? -dist_v : dist_v;
      mag = (mag * longint'(DEG_PER_CM_Q16) + GOAL_ROUND) >>> GOAL_FRAC;
      goal_ang = GOAL_W'(dist_v < 0 ? -mag : mag);
      prev_err = '0;
      err_sum = '0;
      speed_cap = '0;
      tick_cnt = '0;
      last_cmd = '0;
    end else if (tick_cnt >= cfg_now.run) begin
      r.cmd = last_cmd;
      r.done = 1'b1;
    end else begin
      err = longint'(goal_ang) - longint'(ang);
      aerr = err < 0 ? -err : err;
      sum = longint'(err_sum) + err;
      if (sum > SUM_HI) sum = SUM_HI;
      else if (sum < -SUM_HI - 1) sum = -SUM_HI - 1;
      if (aerr > longint'(cfg_now.ilim)) sum = 0;
      err_sum = SUM_W'(sum);
      deriv = err - longint'(prev_err);
      prev_err = GOAL_W'(err);
      pid = longint'(cfg_now.kp) * err + longint'(cfg_now.ki) * sum
          + longint'(cfg_now.kd) * deriv;
      if (pid > PID_LIM) pid = PID_LIM;
      else if (pid < -PID_LIM) pid = -PID_LIM;
      mag = pid < 0 ? -pid : pid;
      if (GAIN_FRAC >= 8) mag = mag >> (GAIN_FRAC - 8);
      else mag = mag << (8 - GAIN_FRAC);
      v = pid < 0 ? -mag : mag;
      if (tick_cnt < cfg_now.accel) begin
        capv = longint'(tick_cnt) * longint'(cfg_now.step);
        if (capv > CAP_LIM) capv = CAP_LIM;
        speed_cap = CAP_W'(dist_v < 0 ? -capv : capv);
      end
      if (dist_v > 0) v = (longint'(speed_cap) < v) ? longint'(speed_cap) : v;
      else v = (longint'(speed_cap) > v) ? longint'(speed_cap) : v;
      if (v > CMD_LIMIT_Q8) v = CMD_LIMIT_Q8;
      else if (v < -CMD_LIMIT_Q8) v = -CMD_LIMIT_Q8;
      mag = (v < 0 ? -v : v) >> CMD_FRAC;
      r.cmd = CMD_W'(v < 0 ? -mag : mag);
      last_cmd = r.cmd;
      tick_cnt++;
    end
    pending_cmds.push_back(r);
  endtask

  task automatic send_word(input logic fn, input logic signed [ANGLE_W-1:0] ang);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    angle <= ang;
    do @(posedge clk); while (in_stall);
    predict_drive(fn, ang);
    words_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic set_config(input drive_cfg_t c);
    write_reg(CFG_TARGET_DISTANCE,
              {{(CFG_DATA_W-DIST_W){c.dist_cm[DIST_W-1]}}, c.dist_cm});
    write_reg(CFG_GAIN_P, c.kp);
    write_reg(CFG_GAIN_I, c.ki);
    write_reg(CFG_GAIN_D, c.kd);
    write_reg(CFG_INTEGRAL_RESET_LIMIT, c.ilim);
    write_reg(CFG_ACCEL_TICKS, {{(CFG_DATA_W-ACCEL_W){1'b0}}, c.accel});
    write_reg(CFG_RAMP_STEP, c.step);
    write_reg(CFG_RUN_TICKS, c.run);
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  function automatic logic signed [ANGLE_W-1:0] angle_near_goal(input int spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    return ANGLE_W'(longint'(goal_ang) + off);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return ANGLE_W'($urandom);
      1: return $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
      2, 3: return angle_near_goal(5000);
      4, 5, 6: return angle_near_goal(300);
      default: return angle_near_goal(20);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input int typical);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return GAIN_W'($urandom_range(0, typical));
    endcase
  endfunction

  function automatic drive_cfg_t rand_cfg();
    drive_cfg_t c;
    case ($urandom_range(0, 5))
      0: c.dist_cm = DIST_MAX;
      1: c.dist_cm = DIST_MIN;
      2: c.dist_cm = '0;
      3: c.dist_cm = DIST_W'($urandom);
      default: c.dist_cm = DIST_W'(int'($urandom_range(0, 1000)) - 500);
    endcase
    c.kp = pick_gain(512);
    c.ki = pick_gain(32);
    c.kd = pick_gain(512);
    c.ilim = pick_gain(400);
    c.step = pick_gain(2000);
    case ($urandom_range(0, 7))
      0: c.accel = '0;
      1: c.accel = '1;
      default: c.accel = ACCEL_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 7))
      0: c.run = '0;
      1: c.run = '1;
      default: c.run = TICK_W'($urandom_range(1, 40));
    endcase
    return c;
  endfunction

  task automatic test_directed_cases();
    drive_cfg_t c;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word(FUNC_TICK, ANGLE_MAX);
    send_word(FUNC_TICK, ANGLE_MIN);
    send_word(FUNC_TICK, '0);
    send_word(FUNC_START, ANGLE_MAX);
    send_word(FUNC_TICK, 21'sd100);
    send_word(FUNC_TICK, -21'sd100);
    wait_results();
    c.dist_cm = DIST_MAX;
    c.kp = '1;
    c.ki = '1;
    c.kd = '1;
    c.ilim = '1;
    c.accel = '1;
    c.step = '1;
    c.run = 16'd3;
    set_config(c);
    send_word(FUNC_START, '0);
    send_word(FUNC_TICK, angle_near_goal(0));
    send_word(FUNC_TICK, ANGLE_MIN);
    send_word(FUNC_TICK, ANGLE_MAX);
    send_word(FUNC_TICK, '0);
    wait_results();
    c.dist_cm = DIST_MIN;
    c.kp = 16'd256;
    c.ki = '0;
    c.kd = '0;
    c.ilim = '0;
    c.accel = '0;
    c.step = '0;
    c.run = '0;
    set_config(c);
    send_word(FUNC_START, ANGLE_MIN);
    send_word(FUNC_TICK, ANGLE_MAX);
    send_word(FUNC_TICK, ANGLE_MIN);
    wait_results();
    c.dist_cm = 13'sd1;
    c.kp = 16'd40;
    c.ki = 16'd3;
    c.kd = 16'd100;
    c.ilim = 16'd50;
    c.accel = 10'd2;
    c.step = 16'd768;
    c.run = 16'd5;
    set_config(c);
    send_word(FUNC_START, '0);
    send_word(FUNC_TICK, '0);
    send_word(FUNC_TICK, 21'sd5);
    send_word(FUNC_TICK, 21'sd11);
    send_word(FUNC_TICK, 21'sd11);
    send_word(FUNC_TICK, 21'sd12);
    send_word(FUNC_TICK, 21'sd100);
    wait_results();
  endtask

  task automatic test_backpressure();
    drive_cfg_t c;
    c.dist_cm = 13'sd200;
    c.kp = 16'd64;
    c.ki = 16'd4;
    c.kd = 16'd32;
    c.ilim = 16'd500;
    c.accel = 10'd10;
    c.step = 16'd700;
    c.run = 16'd20;
    set_config(c);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    -> hold_ev;
    send_word(FUNC_START, '0);
    repeat (29) send_word(FUNC_TICK, angle_near_goal(300));
    wait_results();
  endtask

  task automatic test_random_moves();
    drive_cfg_t c;
    int phase;
    int n_ticks;
    int batch_end;
    logic long_ramp;
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      phase++;
      long_ramp = (phase % 10 == 9);
      c = rand_cfg();
      if (long_ramp) begin
        c.accel = '1;
        c.step = GAIN_W'($urandom_range(63000, 65535));
        c.run = '1;
      end
      wait_results();
      set_config(c);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if (long_ramp) begin
        send_word(FUNC_START, ANGLE_W'($urandom));
        repeat (135) send_word(FUNC_TICK, pick_angle());
      end else begin
        batch_end = words_sent + $urandom_range(25, 55);
        while (words_sent < batch_end) begin
          if ($urandom_range(0, 19) != 0) send_word(FUNC_START, ANGLE_W'($urandom));
          n_ticks = $urandom_range(1, (cfg_now.run > 40 ? 40 : int'(cfg_now.run)) + 6);
          repeat (n_ticks) send_word(FUNC_TICK, pick_angle());
        end
      end
    end
    wait_results();
  endtask

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : rx_hold_off
    rx_hold <= 1'b0;
    forever begin
      @(hold_ev);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  initial begin : result_checker
    drive_result_t want;
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch("word with nothing expected, motor_command", motor_cmd, 0);
        end else begin
          want = pending_cmds.pop_front();
          if (motor_cmd !== want.cmd) report_mismatch("motor_command", motor_cmd, want.cmd);
          if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
        end
        stall_left = rx_idle ? $urandom_range(0, 7) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= rx_hold || (stall_left > 0);
    end
  end

  initial begin : main_seq
    cfg_now.dist_cm = '0;
    cfg_now.kp = 16'd256;
    cfg_now.ki = '0;
    cfg_now.kd = '0;
    cfg_now.ilim = 16'd200;
    cfg_now.accel = 10'd34;
    cfg_now.step = 16'd768;
    cfg_now.run = 16'd334;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_TARGET_DISTANCE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    func <= FUNC_TICK;
    angle <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_backpressure();
    test_random_moves();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cmds.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
